// ===== sv/utf8v_pkg.sv =====
// Shared types and constants for the UTF-8 stream validator.
package utf8v_pkg;

  localparam int unsigned ByteW = 8;

  // Allowed range for the next continuation byte
  typedef enum logic [2:0] {
    RANGE_NORMAL = 3'd0,  // 80-BF
    RANGE_A0_BF  = 3'd1,  // after E0
    RANGE_80_9F  = 3'd2,  // after ED
    RANGE_90_BF  = 3'd3,  // after F0
    RANGE_80_8F  = 3'd4   // after F4
  } range_class_t;

  typedef logic [1:0] pending_t;

  localparam logic [ByteW-1:0] CHAR_TAB   = 8'h09;
  localparam logic [ByteW-1:0] CHAR_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CHAR_CR    = 8'h0D;
  localparam logic [ByteW-1:0] PRINT_LO   = 8'h20;
  localparam logic [ByteW-1:0] PRINT_HI   = 8'h7E;
  localparam logic [ByteW-1:0] LEAD2_LO   = 8'hC2;
  localparam logic [ByteW-1:0] LEAD2_HI   = 8'hDF;
  localparam logic [ByteW-1:0] LEAD3_LO   = 8'hE0;
  localparam logic [ByteW-1:0] LEAD3_SURR = 8'hED;
  localparam logic [ByteW-1:0] LEAD3_HI   = 8'hEF;
  localparam logic [ByteW-1:0] LEAD4_LO   = 8'hF0;
  localparam logic [ByteW-1:0] LEAD4_HI   = 8'hF4;
  localparam logic [ByteW-1:0] CONT_LO    = 8'h80;
  localparam logic [ByteW-1:0] CONT_8F    = 8'h8F;
  localparam logic [ByteW-1:0] CONT_90    = 8'h90;
  localparam logic [ByteW-1:0] CONT_9F    = 8'h9F;
  localparam logic [ByteW-1:0] CONT_A0    = 8'hA0;
  localparam logic [ByteW-1:0] CONT_HI    = 8'hBF;

endpackage

// ===== sv/utf8v_ifs.sv =====
// Valid/ready channel interfaces for string bytes and verdicts.
interface utf8v_byte_if;
  logic                        valid;
  logic                        ready;
  logic [utf8v_pkg::ByteW-1:0] data_byte;
  logic                        last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface utf8v_verdict_if;
  logic valid;
  logic ready;
  logic is_valid;

  modport source (output valid, output is_valid, input ready);
  modport sink   (input valid, input is_valid, output ready);
endinterface

// ===== sv/utf8_stream_validator.sv =====
// Strict restricted UTF-8 validator, one byte per item, verdict on the last byte.
//
// Channels: bytes (sink) carries data_byte and last; verdict (source) carries
// is_valid. Both use valid/ready; an item moves when valid and ready are high
// at a rising edge of clk.
// Every byte without last updates the pending count, the next-byte range class and
// the sticky error flag when it is accepted. A byte with last clears them and loads
// the verdict register, so is_valid appears in the cycle after that byte is accepted.
// Throughput is one byte per cycle; the only limit is the single-entry verdict
// register, which takes a new verdict in the same cycle the old one leaves.
// Bytes without last produce no item and are accepted regardless of the
// verdict channel; a byte with last waits only while a verdict is held.
// If the receiver stalls, the verdict holds and bytes.ready drops while a
// byte with last is offered.
// Synchronous reset (rst high) clears the string state and empties the
// verdict register. After each verdict the string state returns to reset.
// Empty strings cannot be presented and give no verdict.
module utf8_stream_validator (
  input  logic                    clk,
  input  logic                    rst,
  utf8v_byte_if.sink              bytes,
  utf8v_verdict_if.source         verdict
);

  utf8v_pkg::pending_t     pending_count, pending_count_next;
  utf8v_pkg::range_class_t next_range_class, next_range_class_next;
  logic                    error_seen, error_seen_next;
  logic                    out_valid;
  logic                    out_is_valid;

  logic                    accept;
  logic                    cont_ok;
  logic                    str_ok;
  logic [utf8v_pkg::ByteW-1:0] b;

  assign b = bytes.data_byte;

  // Last byte needs a free verdict slot; other bytes go straight through.
  assign bytes.ready = !bytes.last || !out_valid || verdict.ready;
  assign accept      = bytes.valid && bytes.ready;

  always_comb begin
    case (next_range_class)
      utf8v_pkg::RANGE_A0_BF: cont_ok = b inside {[utf8v_pkg::CONT_A0:utf8v_pkg::CONT_HI]};
      utf8v_pkg::RANGE_80_9F: cont_ok = b inside {[utf8v_pkg::CONT_LO:utf8v_pkg::CONT_9F]};
      utf8v_pkg::RANGE_90_BF: cont_ok = b inside {[utf8v_pkg::CONT_90:utf8v_pkg::CONT_HI]};
      utf8v_pkg::RANGE_80_8F: cont_ok = b inside {[utf8v_pkg::CONT_LO:utf8v_pkg::CONT_8F]};
      default:                cont_ok = b inside {[utf8v_pkg::CONT_LO:utf8v_pkg::CONT_HI]};
    endcase
  end

  always_comb begin
    pending_count_next    = pending_count;
    next_range_class_next = next_range_class;
    error_seen_next       = error_seen;
    if (!error_seen) begin
      next_range_class_next = utf8v_pkg::RANGE_NORMAL;
      if (pending_count != 2'd0) begin
        if (cont_ok) begin
          pending_count_next = pending_count - 2'd1;
        end else begin
          error_seen_next    = 1'b1;
          pending_count_next = 2'd0;
        end
      end else if (b inside {utf8v_pkg::CHAR_TAB, utf8v_pkg::CHAR_LF, utf8v_pkg::CHAR_CR,
                             [utf8v_pkg::PRINT_LO:utf8v_pkg::PRINT_HI]}) begin
        pending_count_next = 2'd0;
      end else if (b inside {[utf8v_pkg::LEAD2_LO:utf8v_pkg::LEAD2_HI]}) begin
        pending_count_next = 2'd1;
      end else if (b inside {[utf8v_pkg::LEAD3_LO:utf8v_pkg::LEAD3_HI]}) begin
        pending_count_next = 2'd2;
        if (b == utf8v_pkg::LEAD3_LO) begin
          next_range_class_next = utf8v_pkg::RANGE_A0_BF;
        end else if (b == utf8v_pkg::LEAD3_SURR) begin
          next_range_class_next = utf8v_pkg::RANGE_80_9F;
        end
      end else if (b inside {[utf8v_pkg::LEAD4_LO:utf8v_pkg::LEAD4_HI]}) begin
        pending_count_next = 2'd3;
        if (b == utf8v_pkg::LEAD4_LO) begin
          next_range_class_next = utf8v_pkg::RANGE_90_BF;
        end else if (b == utf8v_pkg::LEAD4_HI) begin
          next_range_class_next = utf8v_pkg::RANGE_80_8F;
        end
      end else begin
        pending_count_next = 2'd0;
        error_seen_next    = 1'b1;
      end
    end
  end

  // Truncated sequences count as invalid.
  assign str_ok = !error_seen_next && (pending_count_next == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count    <= 2'd0;
      next_range_class <= utf8v_pkg::RANGE_NORMAL;
      error_seen       <= 1'b0;
    end else if (accept) begin
      if (bytes.last) begin
        pending_count    <= 2'd0;
        next_range_class <= utf8v_pkg::RANGE_NORMAL;
        error_seen       <= 1'b0;
      end else begin
        pending_count    <= pending_count_next;
        next_range_class <= next_range_class_next;
        error_seen       <= error_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && bytes.last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && bytes.last) begin
      out_is_valid <= str_ok;
    end
  end

  assign verdict.valid    = out_valid;
  assign verdict.is_valid = out_is_valid;

  a_err_clears_pending: assert property (@(posedge clk) disable iff (rst)
    error_seen |-> (pending_count == 2'd0))
    else $error("error flag set with continuation bytes pending");

  a_narrow_range_pending: assert property (@(posedge clk) disable iff (rst)
    (next_range_class != utf8v_pkg::RANGE_NORMAL) |->
      (pending_count == 2'd2 || pending_count == 2'd3))
    else $error("narrow range class outside a sequence start");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    (accept && bytes.last) |=>
      (pending_count == 2'd0 && !error_seen &&
       next_range_class == utf8v_pkg::RANGE_NORMAL))
    else $error("string state not cleared after last byte");

  a_last_gives_verdict: assert property (@(posedge clk) disable iff (rst)
    (accept && bytes.last) |=> (verdict.valid && verdict.is_valid == $past(str_ok)))
    else $error("verdict missing or wrong after last byte");

endmodule
